// ----- rtl/core/tna_pkg.sv -----
package tna_pkg;

   localparam int COORD_W = 16;
   localparam int ACC_W   = 48;
   localparam int IDX_W   = 12;
   localparam int CFG_W   = 13;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;

   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_TRI   = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [CROSS_W-1:0] cross_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vertex_type;

   typedef struct packed {
      acc_type z;
      acc_type y;
      acc_type x;
   } normal_type;

   typedef struct packed {
      cross_type z;
      cross_type y;
      cross_type x;
   } cross_vec_type;

   typedef struct packed {
      acc_type value;
      logic    clip;
   } sat_type;

   // term is far narrower than acc, so one extra bit catches any overflow
   function automatic sat_type sat_add(acc_type acc, cross_type term);
      logic signed [ACC_W:0] sum;
      sat_type               r;
      sum = (ACC_W+1)'(acc) + (ACC_W+1)'(term);
      r.clip = sum[ACC_W] != sum[ACC_W-1];
      if (!r.clip) begin
         r.value = sum[ACC_W-1:0];
      end else if (sum[ACC_W]) begin
         r.value = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         r.value = {1'b0, {(ACC_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/triangle_normal_accumulator.sv -----
// One transaction at a time: the next request is accepted in the cycle after the
// response is loaded. A triangle does three single-port vertex reads, runs the cross
// pipeline and does one normal write-back.
// Reset: synchronous; afterwards the whole normal memory is swept to zero while
// req_ready stays low. Vertex memory is not cleared.
module triangle_normal_accumulator #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [tna_pkg::IDX_W-1:0]           req_corner_a,
   input  logic [tna_pkg::IDX_W-1:0]           req_corner_b,
   input  logic [tna_pkg::IDX_W-1:0]           req_corner_c,
   input  logic signed [tna_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [tna_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [tna_pkg::COORD_W-1:0]  req_pos_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [tna_pkg::ACC_W-1:0]    rsp_normal_x,
   output logic signed [tna_pkg::ACC_W-1:0]    rsp_normal_y,
   output logic signed [tna_pkg::ACC_W-1:0]    rsp_normal_z,
   input  logic                                csr_wr_en,
   input  logic [tna_pkg::CFG_W-1:0]           csr_wr_data
);

   localparam int AW    = $clog2(VERTEX_DEPTH);
   localparam int CNT_W = $clog2(VERTEX_DEPTH + 1);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_CLEAR = 4'd3;
   localparam logic [3:0] S_RDA   = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_RDC   = 4'd6;
   localparam logic [3:0] S_CAP   = 4'd7;
   localparam logic [3:0] S_X1    = 4'd8;
   localparam logic [3:0] S_X2    = 4'd9;
   localparam logic [3:0] S_ACC   = 4'd10;
   localparam logic [3:0] S_RESP  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [tna_pkg::CFG_W-1:0] cfg_ff;
   logic [CNT_W-1:0] count_in_use;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] limit_ff, limit_in;

   logic [1:0] op_ff;
   logic [AW-1:0] a_ff, b_ff, c_ff;
   tna_pkg::vertex_type pos_ff;
   logic [1:0] status_ff, status_in;

   tna_pkg::vertex_type vtx_mem [VERTEX_DEPTH];
   tna_pkg::normal_type nrm_mem [VERTEX_DEPTH];
   tna_pkg::vertex_type vtx_rdata_ff, p0_ff, p1_ff;
   tna_pkg::normal_type nrm_rdata_ff, nrm_wdata;
   logic vtx_we, vtx_re, nrm_we, nrm_re;
   logic [AW-1:0] vtx_addr, nrm_addr;

   tna_pkg::cross_vec_type cross_vec;
   tna_pkg::sat_type sx, sy, sz;

   logic accept, all_ok, a_ok, b_ok, c_ok, sweep_last, rsp_load;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   tna_pkg::normal_type rsp_normal_ff;

   assign count_in_use = (32'(cfg_ff) > 32'(VERTEX_DEPTH)) ? CNT_W'(VERTEX_DEPTH)
                                                           : CNT_W'(cfg_ff);
   assign a_ok = 32'(req_corner_a) < 32'(count_in_use);
   assign b_ok = 32'(req_corner_b) < 32'(count_in_use);
   assign c_ok = 32'(req_corner_c) < 32'(count_in_use);
   assign all_ok = a_ok && (req_opcode != tna_pkg::OP_TRI || (b_ok && c_ok));

   assign req_ready  = state_ff == S_IDLE;
   assign accept     = req_valid && req_ready;
   assign sweep_last = CNT_W'(ptr_ff + CNT_W'(1)) == limit_ff;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   assign sx = tna_pkg::sat_add(nrm_rdata_ff.x, cross_vec.x);
   assign sy = tna_pkg::sat_add(nrm_rdata_ff.y, cross_vec.y);
   assign sz = tna_pkg::sat_add(nrm_rdata_ff.z, cross_vec.z);

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      limit_in  = limit_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_INIT: begin
            ptr_in = CNT_W'(ptr_ff + CNT_W'(1));
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               status_in = tna_pkg::ST_OK;
               ptr_in    = '0;
               limit_in  = count_in_use;
               if (req_opcode == tna_pkg::OP_CLEAR) begin
                  state_in = (count_in_use == '0) ? S_RESP : S_CLEAR;
               end else if (!all_ok) begin
                  status_in = tna_pkg::ST_RANGE;
                  state_in  = S_RESP;
               end else if (req_opcode == tna_pkg::OP_LOAD) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_RDA;
               end
            end
         end
         S_LOAD:  state_in = S_RESP;
         S_CLEAR: begin
            ptr_in = CNT_W'(ptr_ff + CNT_W'(1));
            if (sweep_last) begin
               state_in = S_RESP;
            end
         end
         S_RDA:   state_in = (op_ff == tna_pkg::OP_READ) ? S_RESP : S_RDB;
         S_RDB:   state_in = S_RDC;
         S_RDC:   state_in = S_CAP;
         S_CAP:   state_in = S_X1;
         S_X1:    state_in = S_X2;
         S_X2:    state_in = S_ACC;
         S_ACC: begin
            status_in = (sx.clip || sy.clip || sz.clip) ? tna_pkg::ST_SAT : tna_pkg::ST_OK;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vtx_we   = state_ff == S_LOAD;
      vtx_re   = (op_ff == tna_pkg::OP_TRI) &&
                 (state_ff == S_RDA || state_ff == S_RDB || state_ff == S_RDC);
      vtx_addr = a_ff;
      if (state_ff == S_RDB) begin
         vtx_addr = b_ff;
      end else if (state_ff == S_RDC) begin
         vtx_addr = c_ff;
      end
      nrm_re    = state_ff == S_RDA;
      nrm_we    = state_ff == S_INIT || state_ff == S_CLEAR || state_ff == S_ACC;
      nrm_addr  = (state_ff == S_ACC || state_ff == S_RDA) ? a_ff : ptr_ff[AW-1:0];
      nrm_wdata = '0;
      if (state_ff == S_ACC) begin
         nrm_wdata.x = sx.value;
         nrm_wdata.y = sy.value;
         nrm_wdata.z = sz.value;
      end
   end

   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[vtx_addr] <= pos_ff;
      end else if (vtx_re) begin
         vtx_rdata_ff <= vtx_mem[vtx_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (nrm_we) begin
         nrm_mem[nrm_addr] <= nrm_wdata;
      end else if (nrm_re) begin
         nrm_rdata_ff <= nrm_mem[nrm_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RDB) begin
         p0_ff <= vtx_rdata_ff;
      end
      if (state_ff == S_RDC) begin
         p1_ff <= vtx_rdata_ff;
      end
      if (accept) begin
         op_ff    <= req_opcode;
         a_ff     <= AW'(req_corner_a);
         b_ff     <= AW'(req_corner_b);
         c_ff     <= AW'(req_corner_c);
         pos_ff.x <= req_pos_x;
         pos_ff.y <= req_pos_y;
         pos_ff.z <= req_pos_z;
      end
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_normal_ff <= (op_ff == tna_pkg::OP_READ && status_ff == tna_pkg::ST_OK)
                          ? nrm_rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         limit_ff     <= CNT_W'(VERTEX_DEPTH);
         cfg_ff       <= tna_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         limit_ff <= limit_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // p2 comes straight from the memory output in S_CAP
   tna_cross u_cross (
      .clock     (clock),
      .p0        (p0_ff),
      .p1        (p1_ff),
      .p2        (vtx_rdata_ff),
      .cross_out (cross_vec)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_normal_x = rsp_normal_ff.x;
   assign rsp_normal_y = rsp_normal_ff.y;
   assign rsp_normal_z = rsp_normal_ff.z;

   a_nrm_single_port: assert property (@(posedge clock) disable iff (reset)
      !(nrm_we && nrm_re))
      else $error("normal memory read and write in same cycle");

   a_acc_after_cross: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> ($past(state_ff) == S_X2))
      else $error("accumulate before cross product ready");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |=> !accept || $past(sweep_last))
      else $error("transaction accepted during clearing sweep");

endmodule

// ----- rtl/core/tna_cross.sv -----
module tna_cross (
   input  logic                   clock,
   input  tna_pkg::vertex_type    p0,
   input  tna_pkg::vertex_type    p1,
   input  tna_pkg::vertex_type    p2,
   output tna_pkg::cross_vec_type cross_out
);

   typedef logic signed [tna_pkg::DIFF_W-1:0] diff_type;
   typedef logic signed [tna_pkg::PROD_W-1:0] prod_type;

   diff_type ex_ff, ey_ff, ez_ff, fx_ff, fy_ff, fz_ff;
   prod_type m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   tna_pkg::cross_vec_type cross_ff;

   // three stages: edge vectors, products, cross terms
   always_ff @(posedge clock) begin
      ex_ff <= diff_type'(p1.x) - diff_type'(p0.x);
      ey_ff <= diff_type'(p1.y) - diff_type'(p0.y);
      ez_ff <= diff_type'(p1.z) - diff_type'(p0.z);
      fx_ff <= diff_type'(p2.x) - diff_type'(p0.x);
      fy_ff <= diff_type'(p2.y) - diff_type'(p0.y);
      fz_ff <= diff_type'(p2.z) - diff_type'(p0.z);

      m0_ff <= prod_type'(ey_ff) * prod_type'(fz_ff);
      m1_ff <= prod_type'(ez_ff) * prod_type'(fy_ff);
      m2_ff <= prod_type'(ez_ff) * prod_type'(fx_ff);
      m3_ff <= prod_type'(ex_ff) * prod_type'(fz_ff);
      m4_ff <= prod_type'(ex_ff) * prod_type'(fy_ff);
      m5_ff <= prod_type'(ey_ff) * prod_type'(fx_ff);

      cross_ff.x <= tna_pkg::cross_type'(m0_ff) - tna_pkg::cross_type'(m1_ff);
      cross_ff.y <= tna_pkg::cross_type'(m2_ff) - tna_pkg::cross_type'(m3_ff);
      cross_ff.z <= tna_pkg::cross_type'(m4_ff) - tna_pkg::cross_type'(m5_ff);
   end

   assign cross_out = cross_ff;

endmodule
